// ===== rtl/core/sset_pkg.sv =====
// sset_pkg: shared types and codes for the sorted set block
// holds the command word, the token that walks the cell chain and the fsm states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sset_pkg;

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 6;

    // what the token is doing as it passes a cell
    typedef enum logic [1:0] {
        M_SEARCH,
        M_INS_SHIFT,
        M_DEL_SHIFT,
        M_DONE
    } tok_mode_t;

    // token handed from cell to cell, one cell per cycle
    typedef struct packed {
        logic                     active;
        tok_mode_t                mode;
        logic                     changed;
        logic                     overflow;
        logic signed [DATA_W-1:0] carry_data;
        logic                     carry_valid;
    } tok_t;

    // command word broadcast to every cell while a word is in flight
    typedef struct packed {
        logic                     op;
        logic signed [DATA_W-1:0] value;
        logic                     full;
    } cmd_t;

    // sequencer states
    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/sset_cell.sv =====
// sset_cell: one storage cell of the sorted chain
// holds one entry and its valid bit, acts on the token and hands it to the next cell
// depends on sset_pkg
`timescale 1ns / 1ps
`default_nettype none

module sset_cell (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire sset_pkg::cmd_t                    cmd,
    input  wire sset_pkg::tok_t                    tok_in,
    output sset_pkg::tok_t                         tok_out,
    input  wire logic signed [sset_pkg::DATA_W-1:0] next_entry,
    input  wire logic                              next_valid,
    output logic signed [sset_pkg::DATA_W-1:0]     entry,
    output logic                                   valid
);
    import sset_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     valid_reg;
    logic                     valid_next;
    tok_t                     tok_out_reg;
    tok_t                     tok_next;
    logic                     not_below;
    logic                     hit;

    // local compares against the broadcast value
    assign not_below = !valid_reg || ($signed(entry_reg) >= $signed(cmd.value));
    assign hit       = valid_reg && (entry_reg == cmd.value);

    // cell update and outgoing token
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        tok_next   = tok_in;
        if (tok_in.active)
        begin
            case (tok_in.mode)
                M_SEARCH:
                begin
                    if (not_below)
                    begin
                        if (cmd.op == OP_INSERT)
                        begin
                            if (hit)
                            begin
                                tok_next.mode = M_DONE;
                            end
                            else if (cmd.full)
                            begin
                                tok_next.mode     = M_DONE;
                                tok_next.overflow = 1'b1;
                            end
                            else
                            begin
                                // take the new value, displaced entry moves up
                                entry_next           = cmd.value;
                                valid_next           = 1'b1;
                                tok_next.mode        = M_INS_SHIFT;
                                tok_next.carry_data  = entry_reg;
                                tok_next.carry_valid = valid_reg;
                                tok_next.changed     = 1'b1;
                            end
                        end
                        else
                        begin
                            if (hit)
                            begin
                                // drop this entry, pull the upper neighbor down
                                entry_next       = next_entry;
                                valid_next       = next_valid;
                                tok_next.mode    = M_DEL_SHIFT;
                                tok_next.changed = 1'b1;
                            end
                            else
                            begin
                                tok_next.mode = M_DONE;
                            end
                        end
                    end
                end
                M_INS_SHIFT:
                begin
                    entry_next           = tok_in.carry_data;
                    valid_next           = tok_in.carry_valid;
                    tok_next.carry_data  = entry_reg;
                    tok_next.carry_valid = valid_reg;
                end
                M_DEL_SHIFT:
                begin
                    entry_next = next_entry;
                    valid_next = next_valid;
                end
                default:
                begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            tok_out_reg <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            tok_out_reg <= tok_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign tok_out = tok_out_reg;
    assign entry   = entry_reg;
    assign valid   = valid_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sorted_set_insert_remove_top.sv =====
// sorted_set_insert_remove_top: sorted set of distinct signed 32-bit values
// sequencer, entry count and a chain of sset_cell storage cells
// depends on sset_pkg and sset_cell
//
//   channel   | handshake        | word
//   ----------+------------------+-----------------------------
//   command   | start / busy     | op, value
//   result    | done (strobe)    | changed, count, overflow
//
// after accept a token is injected and walks the cell chain one cell per cycle,
// then the result is registered.
// the result shows for one cycle on done; busy is low in that same cycle.
// the receiver cannot stall; busy holds the sender off while the token walks.
// reset clears the valid bits, the count and the sequencer; entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module sorted_set_insert_remove_top #(
    parameter int CAPACITY = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              op,
    input  wire logic signed [sset_pkg::DATA_W-1:0] value,
    output logic                                   done,
    output logic                                   changed,
    output logic [sset_pkg::COUNT_W-1:0]           count,
    output logic                                   overflow
);
    import sset_pkg::*;

    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int CWX = (CW > COUNT_W) ? CW : COUNT_W;

    state_t                   state_reg;
    state_t                   state_next;
    cmd_t                     cmd_reg;
    cmd_t                     cmd_next;
    tok_t                     inj_reg;
    tok_t                     inj_next;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     done_reg;
    logic                     done_next;
    logic                     changed_reg;
    logic                     changed_next;
    logic                     overflow_reg;
    logic                     overflow_next;
    logic                     accept;
    logic                     finish;
    logic [CWX-1:0]           count_wide;

    tok_t                     tok [0:CAPACITY];
    logic signed [DATA_W-1:0] ent [0:CAPACITY];
    logic                     vld [0:CAPACITY];

    assign accept = start && !busy;
    assign finish = tok[CAPACITY].active;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        case (state_reg)
            ST_IDLE: busy = 1'b0;
            ST_RUN:  busy = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    // command latch and token injection
    always_comb
    begin
        cmd_next = cmd_reg;
        inj_next = '0;
        if (accept)
        begin
            cmd_next.op    = op;
            cmd_next.value = value;
            cmd_next.full  = (count_reg == CW'(CAPACITY));
            inj_next.active = 1'b1;
            inj_next.mode   = M_SEARCH;
        end
    end

    // result and count update when the token leaves the chain
    always_comb
    begin
        count_next    = count_reg;
        done_next     = 1'b0;
        changed_next  = changed_reg;
        overflow_next = overflow_reg;
        if (finish)
        begin
            done_next    = 1'b1;
            changed_next = tok[CAPACITY].changed;
            // still searching at the end means an insert into a full store
            overflow_next = tok[CAPACITY].overflow ||
                            ((tok[CAPACITY].mode == M_SEARCH) && (cmd_reg.op == OP_INSERT));
            if (tok[CAPACITY].changed)
            begin
                if (cmd_reg.op == OP_INSERT)
                begin
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            inj_reg      <= '0;
            count_reg    <= '0;
            done_reg     <= 1'b0;
            changed_reg  <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            inj_reg      <= inj_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            changed_reg  <= changed_next;
            overflow_reg <= overflow_next;
        end
    end

    // command payload
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    // cell chain
    assign tok[0]        = inj_reg;
    assign ent[CAPACITY] = '0;
    assign vld[CAPACITY] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        sset_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd_reg),
            .tok_in     (tok[i]),
            .tok_out    (tok[i+1]),
            .next_entry (ent[i+1]),
            .next_valid (vld[i+1]),
            .entry      (ent[i]),
            .valid      (vld[i])
        );
    end

    // outputs
    assign count_wide = CWX'(count_reg);
    assign count      = count_wide[COUNT_W-1:0];
    assign done       = done_reg;
    assign changed    = changed_reg;
    assign overflow   = overflow_reg;

endmodule

`default_nettype wire
